// ----- hw/rtl/esd_pkg.sv -----
// Shared types, character codes and byte classifiers for the escape sequence decoder.
package esd_pkg;

	typedef enum logic [2:0] {
		MODE_NORMAL = 3'd0,
		MODE_ESC    = 3'd1,
		MODE_OCT    = 3'd2,
		MODE_HEX0   = 3'd3,
		MODE_HEX1   = 3'd4
	} mode_t;

	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_X      = 8'h78;
	localparam logic [1:0] OCT_MAX   = 2'd3;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} result_t;

	function automatic logic is_oct(input logic [7:0] b);
		return (b >= 8'h30) && (b <= 8'h37);
	endfunction

	function automatic logic is_hex(input logic [7:0] b);
		return ((b >= 8'h30) && (b <= 8'h39)) ||
		       ((b >= 8'h61) && (b <= 8'h66)) ||
		       ((b >= 8'h41) && (b <= 8'h46));
	endfunction

	function automatic logic [3:0] hex_val(input logic [7:0] b);
		logic [3:0] v;
		v = 4'd0;
		if ((b >= 8'h30) && (b <= 8'h39)) begin
			v = b[3:0];
		end else if (((b >= 8'h61) && (b <= 8'h66)) || ((b >= 8'h41) && (b <= 8'h46))) begin
			// letters a-f / A-F share the low three bits 1..6
			v = 4'(b[2:0] + 3'd1) + 4'd8;
		end
		return v;
	endfunction

	function automatic logic [7:0] simple_escape(input logic [7:0] b);
		logic [7:0] v;
		v = b;
		unique case (b)
			8'h61:   v = 8'h07; // a
			8'h62:   v = 8'h08; // b
			8'h65:   v = 8'h1B; // e
			8'h66:   v = 8'h0C; // f
			8'h6E:   v = 8'h0A; // n
			8'h72:   v = 8'h0D; // r
			8'h74:   v = 8'h09; // t
			8'h76:   v = 8'h0B; // v
			default: v = b;
		endcase
		return v;
	endfunction

endpackage

// ----- hw/rtl/escape_sequence_decoder_core.sv -----
// Escape sequence decoder: unescapes a C-style escaped byte stream.
//
// Input channel (in_valid/in_ready): one raw byte per transfer plus string_end,
// which marks the final byte of a string and flushes any pending escape.
// Output channel (out_valid/out_ready): one decoded byte per transfer; run_last
// is set on the last result produced by an input byte. A byte yields 0, 1 or 2
// results.
// A byte taken into the input register is decoded there; its results land in
// the two-entry result register, from which they are offered, once that
// register has room.
// Throughput: one byte per cycle while each byte gives at most one result and
// out_ready stays high; a byte that gives two results holds the result register
// for two output transfers, which stalls a following byte that has results.
// A stalled receiver backs up into the result register and then the input
// register; in_ready drops once both are full.
// Reset (arst_n low) empties both registers and returns the parser to normal
// text mode.
module escape_sequence_decoder_core (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_byte,
	input  logic       string_end,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic       run_last
);

	// input register
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       end_s1;

	// parser state
	esd_pkg::mode_t mode_q, mode_d;
	logic [7:0]     num_q, num_d;
	logic [1:0]     cnt_q, cnt_d;

	// result register
	esd_pkg::result_t res0_q, res1_q;
	logic [1:0]       out_cnt_q;

	// decode outputs
	logic             emit_num;
	logic [7:0]       num_val;
	logic             do_plain;
	logic [1:0]       n_res;
	esd_pkg::result_t r0, r1;

	logic pop, room, adv;

	always_comb begin
		logic [7:0] b;
		logic       fin;
		b = byte_s1;
		fin = end_s1;
		mode_d = mode_q;
		num_d = num_q;
		cnt_d = cnt_q;
		emit_num = 1'b0;
		num_val = num_q;
		do_plain = 1'b0;
		unique case (mode_q)
			esd_pkg::MODE_ESC: begin
				if (esd_pkg::is_oct(b)) begin
					num_d = {5'd0, b[2:0]};
					num_val = {5'd0, b[2:0]};
					cnt_d = 2'd1;
					mode_d = esd_pkg::MODE_OCT;
					emit_num = fin;
				end else if (b == esd_pkg::CH_X) begin
					mode_d = esd_pkg::MODE_HEX0;
				end else begin
					emit_num = 1'b1;
					num_val = esd_pkg::simple_escape(b);
					mode_d = esd_pkg::MODE_NORMAL;
				end
			end
			esd_pkg::MODE_OCT: begin
				if (esd_pkg::is_oct(b) && (cnt_q < esd_pkg::OCT_MAX)) begin
					num_d = {num_q[4:0], b[2:0]};
					num_val = {num_q[4:0], b[2:0]};
					cnt_d = 2'(cnt_q + 2'd1);
					if ((cnt_d == esd_pkg::OCT_MAX) || fin) begin
						emit_num = 1'b1;
						mode_d = esd_pkg::MODE_NORMAL;
					end
				end else begin
					emit_num = 1'b1;
					do_plain = 1'b1;
				end
			end
			esd_pkg::MODE_HEX0: begin
				if (esd_pkg::is_hex(b)) begin
					num_d = {4'd0, esd_pkg::hex_val(b)};
					num_val = {4'd0, esd_pkg::hex_val(b)};
					mode_d = esd_pkg::MODE_HEX1;
					emit_num = fin;
				end else begin
					do_plain = 1'b1;
				end
			end
			esd_pkg::MODE_HEX1: begin
				if (esd_pkg::is_hex(b)) begin
					num_d = {num_q[3:0], esd_pkg::hex_val(b)};
					num_val = {num_q[3:0], esd_pkg::hex_val(b)};
					emit_num = 1'b1;
					mode_d = esd_pkg::MODE_NORMAL;
				end else begin
					emit_num = 1'b1;
					do_plain = 1'b1;
				end
			end
			default: begin
				do_plain = 1'b1;
			end
		endcase

		if (do_plain) begin
			mode_d = (b == esd_pkg::CH_BSLASH) ? esd_pkg::MODE_ESC : esd_pkg::MODE_NORMAL;
		end
		if (mode_d == esd_pkg::MODE_NORMAL) begin
			num_d = 8'd0;
			cnt_d = 2'd0;
		end
		if (fin) begin
			mode_d = esd_pkg::MODE_NORMAL;
			num_d = 8'd0;
			cnt_d = 2'd0;
		end

		// a pending number always goes out ahead of the byte that ended it
		n_res = 2'(emit_num) + 2'(do_plain && (b != esd_pkg::CH_BSLASH));
		r0.data = emit_num ? num_val : b;
		r0.last = (n_res == 2'd1);
		r1.data = b;
		r1.last = 1'b1;
	end

	assign pop = out_valid && out_ready;
	assign room = (out_cnt_q == 2'd0) || ((out_cnt_q == 2'd1) && pop);
	assign adv = valid_s1 && (room || (n_res == 2'd0));
	assign in_ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= in_byte;
			end_s1 <= string_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= esd_pkg::MODE_NORMAL;
			num_q <= 8'd0;
			cnt_q <= 2'd0;
		end else if (adv) begin
			mode_q <= mode_d;
			num_q <= num_d;
			cnt_q <= cnt_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_cnt_q <= 2'd0;
		end else if (adv && (n_res != 2'd0)) begin
			out_cnt_q <= n_res;
		end else if (pop) begin
			out_cnt_q <= 2'(out_cnt_q - 2'd1);
		end
	end

	always_ff @(posedge clk) begin
		if (adv && (n_res != 2'd0)) begin
			res0_q <= r0;
			res1_q <= r1;
		end else if (pop) begin
			res0_q <= res1_q;
		end
	end

	assign out_valid = (out_cnt_q != 2'd0);
	assign out_byte = res0_q.data;
	assign run_last = res0_q.last;

	a_out_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_cnt_q != 2'd3)
		else $error("result count out of range");

	a_oct_count: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q == esd_pkg::MODE_OCT) |-> ((cnt_q == 2'd1) || (cnt_q == 2'd2)))
		else $error("octal digit count invalid in octal mode");

	a_normal_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q == esd_pkg::MODE_NORMAL) |-> ((num_q == 8'd0) && (cnt_q == 2'd0)))
		else $error("number state not cleared in normal mode");

	a_pair_order: assert property (@(posedge clk) disable iff (!arst_n)
		(out_cnt_q == 2'd2) |-> (!res0_q.last && res1_q.last))
		else $error("last flag misplaced in result pair");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !adv) |=> (valid_s1 && $stable(byte_s1) && $stable(end_s1)))
		else $error("input register lost a byte while stalled");

endmodule

// ----- sim/escape_sequence_decoder_core_test.sv -----
// Self-checking testbench for the escape sequence decoder core: directed table then random strings and stray bytes.
module escape_sequence_decoder_core_test;

	localparam int DIRECTED_ROWS = 25;
	localparam int RANDOM_ITEMS  = 400;
	localparam int CYCLE_LIMIT   = 200000;
	localparam int SHOWN_ERRORS  = 20;

	// one input byte; typed rows carry the expected result inline
	typedef struct packed {
		logic [7:0] b;
		logic       fin;
		logic       typed;
		logic [1:0] n;
		logic [7:0] e0;
	} feed_t;

	localparam feed_t DIRECTED [DIRECTED_ROWS] = '{
		'{8'h00,              1'b0, 1'b1, 2'd1, 8'h00},
		'{8'hFF,              1'b1, 1'b1, 2'd1, 8'hFF},
		'{esd_pkg::CH_BSLASH, 1'b0, 1'b1, 2'd0, 8'h00},
		'{"e",                1'b0, 1'b1, 2'd1, 8'h1B},
		// three octal digits, 0777 wraps to 0xFF
		'{esd_pkg::CH_BSLASH, 1'b0, 1'b1, 2'd0, 8'h00},
		'{"7",                1'b0, 1'b1, 2'd0, 8'h00},
		'{"7",                1'b0, 1'b1, 2'd0, 8'h00},
		'{"7",                1'b0, 1'b1, 2'd1, 8'hFF},
		'{esd_pkg::CH_BSLASH, 1'b0, 1'b1, 2'd0, 8'h00},
		'{esd_pkg::CH_X,      1'b0, 1'b1, 2'd0, 8'h00},
		'{"F",                1'b0, 1'b1, 2'd0, 8'h00},
		'{"f",                1'b0, 1'b1, 2'd1, 8'hFF},
		// hex number cut short by a plain byte: two results
		'{esd_pkg::CH_BSLASH, 1'b0, 1'b0, 2'd0, 8'h00},
		'{esd_pkg::CH_X,      1'b0, 1'b0, 2'd0, 8'h00},
		'{"4",                1'b0, 1'b0, 2'd0, 8'h00},
		'{"g",                1'b0, 1'b0, 2'd0, 8'h00},
		// octal cut by a new escape, then x with no hex digit
		'{esd_pkg::CH_BSLASH, 1'b0, 1'b0, 2'd0, 8'h00},
		'{"5",                1'b0, 1'b0, 2'd0, 8'h00},
		'{esd_pkg::CH_BSLASH, 1'b0, 1'b0, 2'd0, 8'h00},
		'{esd_pkg::CH_X,      1'b0, 1'b0, 2'd0, 8'h00},
		'{"Z",                1'b0, 1'b0, 2'd0, 8'h00},
		// bare x at string end gives nothing; pending digit at end is flushed
		'{esd_pkg::CH_BSLASH, 1'b0, 1'b1, 2'd0, 8'h00},
		'{esd_pkg::CH_X,      1'b1, 1'b1, 2'd0, 8'h00},
		'{esd_pkg::CH_BSLASH, 1'b0, 1'b1, 2'd0, 8'h00},
		'{"3",                1'b1, 1'b1, 2'd1, 8'h03}
	};

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_ready;
	logic [7:0] in_byte;
	logic       string_end;
	logic       out_valid;
	logic       out_ready;
	logic [7:0] out_byte;
	logic       run_last;

	escape_sequence_decoder_core dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_byte    (in_byte),
		.string_end (string_end),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_byte   (out_byte),
		.run_last   (run_last)
	);

	// decoder state as the testbench sees it
	esd_pkg::mode_t scan_mode;
	logic [7:0]     num_acc;
	logic [1:0]     oct_taken;
	logic [7:0]     dec_byte [2];
	int             dec_n;

	feed_t            stim_q [$];
	esd_pkg::result_t decoded_due [$];
	string            esc_letters = "abefnrtv\\'\"?";

	int n_bad = 0;
	int n_out = 0;
	int n_strings = 0;
	int n_pairs = 0;
	int cyc = 0;
	bit calm;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
	end

	function automatic bit is_octal_char(input logic [7:0] b);
		return b >= "0" && b <= "7";
	endfunction

	function automatic bit is_hex_char(input logic [7:0] b);
		return (b >= "0" && b <= "9") || (b >= "a" && b <= "f") || (b >= "A" && b <= "F");
	endfunction

	function automatic logic [3:0] hex_nibble(input logic [7:0] b);
		if (b >= "a")
			return 4'(b - "a" + 10);
		if (b >= "A")
			return 4'(b - "A" + 10);
		return b[3:0];
	endfunction

	function automatic logic [7:0] escape_value(input logic [7:0] b);
		case (b)
			"a":     return 8'h07;
			"b":     return 8'h08;
			"e":     return 8'h1B;
			"f":     return 8'h0C;
			"n":     return 8'h0A;
			"r":     return 8'h0D;
			"t":     return 8'h09;
			"v":     return 8'h0B;
			default: return b;
		endcase
	endfunction

	function automatic void put_dec(input logic [7:0] v);
		dec_byte[dec_n] = v;
		dec_n++;
	endfunction

	function automatic void plain_byte(input logic [7:0] b);
		if (b == esd_pkg::CH_BSLASH) begin
			scan_mode = esd_pkg::MODE_ESC;
		end else begin
			scan_mode = esd_pkg::MODE_NORMAL;
			put_dec(b);
		end
	endfunction

	// decoded bytes for one input byte land in dec_byte[0 .. dec_n-1]
	function automatic void decode_byte(input logic [7:0] b, input logic fin);
		dec_n = 0;
		case (scan_mode)
			esd_pkg::MODE_ESC: begin
				if (is_octal_char(b)) begin
					num_acc = {5'd0, b[2:0]};
					oct_taken = 2'd1;
					scan_mode = esd_pkg::MODE_OCT;
					if (fin)
						put_dec(num_acc);
				end else if (b == esd_pkg::CH_X) begin
					scan_mode = esd_pkg::MODE_HEX0;
				end else begin
					put_dec(escape_value(b));
					scan_mode = esd_pkg::MODE_NORMAL;
				end
			end
			esd_pkg::MODE_OCT: begin
				if (is_octal_char(b) && oct_taken < esd_pkg::OCT_MAX) begin
					num_acc = {num_acc[4:0], b[2:0]};
					oct_taken = oct_taken + 2'd1;
					if (oct_taken >= esd_pkg::OCT_MAX || fin) begin
						put_dec(num_acc);
						scan_mode = esd_pkg::MODE_NORMAL;
					end
				end else begin
					put_dec(num_acc);
					plain_byte(b);
				end
			end
			esd_pkg::MODE_HEX0: begin
				if (is_hex_char(b)) begin
					num_acc = {4'd0, hex_nibble(b)};
					scan_mode = esd_pkg::MODE_HEX1;
					if (fin)
						put_dec(num_acc);
				end else begin
					plain_byte(b);
				end
			end
			esd_pkg::MODE_HEX1: begin
				if (is_hex_char(b)) begin
					num_acc = {num_acc[3:0], hex_nibble(b)};
					put_dec(num_acc);
					scan_mode = esd_pkg::MODE_NORMAL;
				end else begin
					put_dec(num_acc);
					plain_byte(b);
				end
			end
			default: plain_byte(b);
		endcase
		if (scan_mode == esd_pkg::MODE_NORMAL || fin) begin
			num_acc = 8'h00;
			oct_taken = 2'd0;
		end
		if (fin)
			scan_mode = esd_pkg::MODE_NORMAL;
	endfunction

	task automatic report_mismatch(input string what);
		if (n_bad < SHOWN_ERRORS)
			$display("MISMATCH cycle %0d: %s", cyc, what);
		n_bad++;
	endtask

	// called once per input transfer
	task automatic expect_item(input feed_t f);
		esd_pkg::result_t r;
		int i;
		decode_byte(f.b, f.fin);
		if (f.fin)
			n_strings++;
		if (f.typed) begin
			if (f.n != 2'd0) begin
				r.data = f.e0;
				r.last = 1'b1;
				decoded_due.push_back(r);
			end
		end else begin
			if (dec_n == 2)
				n_pairs++;
			for (i = 0; i < dec_n; i++) begin
				r.data = dec_byte[i];
				r.last = (i == dec_n - 1);
				decoded_due.push_back(r);
			end
		end
	endtask

	task automatic add_byte(input logic [7:0] b, input logic fin);
		feed_t f;
		f = '0;
		f.b = b;
		f.fin = fin;
		stim_q.push_back(f);
	endtask

	function automatic logic [7:0] random_hex_char();
		int k;
		k = $urandom_range(0, 21);
		if (k < 10)
			return 8'("0" + k);
		if (k < 16)
			return 8'("a" + k - 10);
		return 8'("A" + k - 16);
	endfunction

	function automatic int pick_idle_pct();
		case ($urandom_range(0, 2))
			0:       return 0;
			1:       return 10;
			default: return 35;
		endcase
	endfunction

	// a string built from plain bytes and escapes; now and then left unterminated
	task automatic add_random_string();
		logic [7:0] body [$];
		int ntok;
		int t;
		int nd;
		int j;
		bit open_end;
		ntok = $urandom_range(1, 6);
		for (t = 0; t < ntok; t++) begin
			case ($urandom_range(0, 9))
				0, 1, 2: begin
					if ($urandom_range(0, 1))
						body.push_back(8'($urandom_range(32, 126)));
					else
						body.push_back(8'($urandom_range(0, 255)));
				end
				3, 4: begin
					body.push_back(esd_pkg::CH_BSLASH);
					if ($urandom_range(0, 4) == 0)
						body.push_back(8'($urandom_range(0, 255)));
					else
						body.push_back(esc_letters[$urandom_range(0, esc_letters.len() - 1)]);
				end
				5, 6: begin
					body.push_back(esd_pkg::CH_BSLASH);
					nd = $urandom_range(1, 3);
					for (j = 0; j < nd; j++)
						body.push_back(8'("0" + $urandom_range(0, 7)));
					// an 8 or 9 ends the number without being a digit
					if ($urandom_range(0, 3) == 0)
						body.push_back(8'("8" + $urandom_range(0, 1)));
				end
				7, 8: begin
					body.push_back(esd_pkg::CH_BSLASH);
					body.push_back(esd_pkg::CH_X);
					nd = $urandom_range(0, 2);
					for (j = 0; j < nd; j++)
						body.push_back(random_hex_char());
				end
				default: body.push_back(esd_pkg::CH_BSLASH);
			endcase
		end
		open_end = ($urandom_range(0, 9) == 0);
		for (j = 0; j < body.size(); j++)
			add_byte(body[j], (j == body.size() - 1) && !open_end);
	endtask

	initial begin : feed
		int k;
		int gap_pct;
		in_valid <= 1'b0;
		in_byte <= 8'h00;
		string_end <= 1'b0;
		calm = 1'b0;
		gap_pct = 0;
		for (k = 0; k < DIRECTED_ROWS; k++)
			stim_q.push_back(DIRECTED[k]);
		while (stim_q.size() < DIRECTED_ROWS + RANDOM_ITEMS) begin
			if ($urandom_range(0, 6) == 0) begin
				repeat ($urandom_range(1, 4))
					add_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
			end else begin
				add_random_string();
			end
		end
		scan_mode = esd_pkg::MODE_NORMAL;
		num_acc = 8'h00;
		oct_taken = 2'd0;

		wait (arst_n);
		@(posedge clk);
		for (k = 0; k < stim_q.size(); k++) begin
			if (k % 50 == 0)
				gap_pct = pick_idle_pct();
			calm = (k >= stim_q.size() * 17 / 20);
			if (!calm && gap_pct != 0 && $urandom_range(1, 100) <= gap_pct) begin
				in_valid <= 1'b0;
				repeat ($urandom_range(1, 17)) @(posedge clk);
			end
			in_valid <= 1'b1;
			in_byte <= stim_q[k].b;
			string_end <= stim_q[k].fin;
			do
				@(posedge clk);
			while (!in_ready);
			expect_item(stim_q[k]);
		end
		in_valid <= 1'b0;

		while (decoded_due.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		$display("sent %0d bytes in %0d terminated strings; %0d decoded bytes checked",
			stim_q.size(), n_strings, n_out);
		$display("bytes that gave two results: %0d", n_pairs);
		if (n_bad == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	initial begin : drain
		int stall_pct;
		int n;
		out_ready <= 1'b0;
		stall_pct = 0;
		n = 0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (n % 64 == 0)
				stall_pct = pick_idle_pct();
			n++;
			if (!calm && stall_pct != 0 && $urandom_range(1, 100) <= stall_pct) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 17)) @(posedge clk);
			end
			out_ready <= 1'b1;
		end
	end

	// compare each output transfer with the oldest decoded byte still due
	always @(posedge clk) begin
		esd_pkg::result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (decoded_due.size() == 0) begin
				report_mismatch($sformatf("unexpected byte %02h last %0b", out_byte, run_last));
			end else begin
				want = decoded_due.pop_front();
				n_out++;
				if (out_byte !== want.data)
					report_mismatch($sformatf("out_byte %02h, expected %02h", out_byte, want.data));
				if (run_last !== want.last)
					report_mismatch($sformatf("run_last %0b, expected %0b (byte %02h)",
						run_last, want.last, want.data));
			end
		end
	end

	always @(posedge clk) begin
		cyc <= cyc + 1;
		if (cyc == CYCLE_LIMIT) begin
			$display("timeout with %0d decoded bytes still due", decoded_due.size());
			$display("end of test: mismatches");
			$finish;
		end
	end

endmodule
